[sv/lacp_pkg.sv]
// Package with the shared types and constants of the cache admission policy block.
package lacp_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_CACHE_BLOCKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_META_BLOCKS  = 1'd1;

    // Register widths and reset values
    localparam int CBLK_W = 7;
    localparam int META_W = 16;
    localparam logic [CBLK_W-1:0] CBLK_RESET = 7'd64;
    localparam logic [META_W-1:0] META_RESET = 16'd256;
    localparam logic [META_W-1:0] LIMIT_RESET = META_W'(META_RESET / 10);

    // Division by ten as a multiply by the reciprocal, exact below 2**18
    localparam int PROD_W = 32;
    localparam logic [PROD_W-1:0] RECIP10 = 32'd52429;
    localparam int RECIP10_SHIFT = 19;
    localparam logic [META_W-1:0] ROUND_UP10 = 16'd9;

    // Stream payload widths
    localparam int IN_ADDR_W   = 32;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;
    localparam int OP_W        = 3;
    localparam int SLOT_W      = 6;
    localparam int EV_ADDR_W   = 32;

    // Input queue between the front and the back
    localparam int Q_DEPTH = 2;

    // Serial divider
    localparam int DIV_W  = 16;
    localparam int DIV_CW = $clog2(DIV_W);

    typedef enum logic [OP_W-1:0] {
        OP_HIT     = 3'd0,
        OP_NEW     = 3'd1,
        OP_REPLACE = 3'd2,
        OP_FILTER  = 3'd3,
        OP_FAIL    = 3'd4
    } t_op;

    // What a queue sweep found
    typedef struct packed {
        logic hit;
        logic lru;
        logic free;
    } t_scan_flags;

    // What a queue update sweep does
    typedef struct packed {
        logic touch;
        logic drop;
        logic push;
        logic inc;
    } t_upd_ctl;

endpackage

[sv/lacp_front.sv]
// Front end: accepts access items, masks the address and queues them for the back end.
module lacp_front #(
    parameter int ADDR_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [lacp_pkg::IN_ADDR_W-1:0]      i_in_addr,
    input  logic                                i_in_write,
    output logic                                o_q_valid,
    input  logic                                i_q_pop,
    output logic [ADDR_BITS-1:0]                o_q_addr,
    output logic                                o_q_write
);

    localparam int QIW = (lacp_pkg::Q_DEPTH > 1) ? $clog2(lacp_pkg::Q_DEPTH) : 1;
    localparam int QCW = $clog2(lacp_pkg::Q_DEPTH + 1);

    logic [ADDR_BITS-1:0] r_addr [lacp_pkg::Q_DEPTH];
    logic                 r_write [lacp_pkg::Q_DEPTH];
    logic [QIW-1:0]       r_wp, r_rp;
    logic [QCW-1:0]       r_cnt;
    logic                 push, pop;

    assign o_in_ready = (r_cnt != QCW'(lacp_pkg::Q_DEPTH));
    assign o_q_valid  = (r_cnt != '0);
    assign push       = i_in_valid && o_in_ready;
    assign pop        = i_q_pop && o_q_valid;
    assign o_q_addr   = r_addr[r_rp];
    assign o_q_write  = r_write[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                // The address is cut down to the configured address width here.
                r_addr[r_wp]  <= ADDR_BITS'(i_in_addr);
                r_write[r_wp] <= i_in_write;
                r_wp <= (r_wp == QIW'(lacp_pkg::Q_DEPTH - 1)) ? '0 : r_wp + QIW'(1);
            end
            if (pop) begin
                r_rp <= (r_rp == QIW'(lacp_pkg::Q_DEPTH - 1)) ? '0 : r_rp + QIW'(1);
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + QCW'(1);
            end else if (pop && !push) begin
                r_cnt <= r_cnt - QCW'(1);
            end
        end
    end

endmodule

[sv/lacp_lru.sv]
// LRU queue store: tag and rank memories with valid bits, swept for lookup and for update.
module lacp_lru #(
    parameter int DEPTH = 64,
    parameter int AW    = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_scan,
    input  logic [AW-1:0]               i_addr,
    input  lacp_pkg::t_upd_ctl          i_ctl,
    input  logic [$clog2(DEPTH)-1:0]    i_sel_idx,
    input  logic [$clog2(DEPTH)-1:0]    i_sel_rank,
    input  logic [$clog2(DEPTH)-1:0]    i_push_idx,
    output logic                        o_done,
    output lacp_pkg::t_scan_flags       o_flags,
    output logic [$clog2(DEPTH)-1:0]    o_hit_idx,
    output logic [$clog2(DEPTH)-1:0]    o_hit_rank,
    output logic [$clog2(DEPTH)-1:0]    o_lru_idx,
    output logic [$clog2(DEPTH)-1:0]    o_lru_rank,
    output logic [AW-1:0]               o_lru_tag,
    output logic [$clog2(DEPTH)-1:0]    o_free_idx
);

    localparam int IW = $clog2(DEPTH);

    logic [AW-1:0]    mem_tag  [DEPTH];
    logic [IW-1:0]    mem_rank [DEPTH];
    logic [DEPTH-1:0] r_valid;

    logic                  r_busy, r_scan, r_pv, r_plast, r_done;
    logic [IW-1:0]         r_idx, r_pj;
    logic [AW-1:0]         r_tag_q;
    logic [IW-1:0]         r_rank_q;
    lacp_pkg::t_scan_flags r_flags;
    logic [IW-1:0]         r_hit_idx, r_hit_rank, r_lru_idx, r_lru_rank, r_free_idx;
    logic [AW-1:0]         r_lru_tag;

    logic          v, is_push;
    logic          n_valid;
    logic [IW-1:0] n_rank;

    assign v       = r_valid[r_pj];
    assign is_push = i_ctl.push && (r_pj == i_push_idx);

    // New rank and valid bit of the entry now under the sweep.
    always_comb begin
        n_valid = v;
        n_rank  = r_rank_q;
        if (i_ctl.touch) begin
            if (r_pj == i_sel_idx) begin
                n_rank = '0;
            end else if (v && r_rank_q < i_sel_rank) begin
                n_rank = r_rank_q + IW'(1);
            end
        end else if (i_ctl.drop && r_pj == i_sel_idx) begin
            n_valid = 1'b0;
        end else if (v) begin
            n_rank = r_rank_q - IW'(i_ctl.drop && r_rank_q > i_sel_rank) + IW'(i_ctl.inc);
        end
        if (is_push) begin
            n_valid = 1'b1;
            n_rank  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_tag_q  <= mem_tag[r_idx];
            r_rank_q <= mem_rank[r_idx];
        end
        if (r_pv && !r_scan) begin
            mem_rank[r_pj] <= n_rank;
            if (is_push) begin
                mem_tag[r_pj] <= i_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_scan  <= 1'b0;
            r_pv    <= 1'b0;
            r_plast <= 1'b0;
            r_done  <= 1'b0;
            r_valid <= '0;
            r_flags <= '0;
        end else begin
            r_done  <= 1'b0;
            r_pv    <= r_busy;
            r_pj    <= r_idx;
            r_plast <= r_busy && (r_idx == IW'(DEPTH - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_scan <= i_scan;
                r_idx  <= '0;
                if (i_scan) begin
                    r_flags <= '0;
                end
            end else if (r_busy) begin
                r_idx <= r_idx + IW'(1);
                if (r_idx == IW'(DEPTH - 1)) begin
                    r_busy <= 1'b0;
                end
            end
            if (r_pv && r_plast) begin
                r_done <= 1'b1;
            end
            if (r_pv && !r_scan) begin
                r_valid[r_pj] <= n_valid;
            end
            if (r_pv && r_scan) begin
                if (v && r_tag_q == i_addr && !r_flags.hit) begin
                    r_flags.hit <= 1'b1;
                    r_hit_idx   <= r_pj;
                    r_hit_rank  <= r_rank_q;
                end
                if (v && (!r_flags.lru || r_rank_q > r_lru_rank)) begin
                    r_flags.lru <= 1'b1;
                    r_lru_idx   <= r_pj;
                    r_lru_rank  <= r_rank_q;
                    r_lru_tag   <= r_tag_q;
                end
                if (!v && !r_flags.free) begin
                    r_flags.free <= 1'b1;
                    r_free_idx   <= r_pj;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_flags    = r_flags;
    assign o_hit_idx  = r_hit_idx;
    assign o_hit_rank = r_hit_rank;
    assign o_lru_idx  = r_lru_idx;
    assign o_lru_rank = r_lru_rank;
    assign o_lru_tag  = r_lru_tag;
    assign o_free_idx = r_free_idx;

endmodule

[sv/lacp_div.sv]
// Restoring serial divider, one quotient bit per cycle.
module lacp_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [lacp_pkg::DIV_W-1:0]    i_num,
    input  logic [lacp_pkg::DIV_W-1:0]    i_den,
    output logic                          o_done,
    output logic [lacp_pkg::DIV_W-1:0]    o_quo
);

    localparam int W = lacp_pkg::DIV_W;

    logic                       r_busy, r_done;
    logic [lacp_pkg::DIV_CW-1:0] r_cnt;
    logic [W-1:0]               r_rem, r_quo, r_den;
    logic [W:0]                 sh, diff;
    logic                       ge;

    assign sh   = {r_rem, r_quo[W-1]};
    assign diff = sh - {1'b0, r_den};
    assign ge   = (sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= lacp_pkg::DIV_CW'(W - 1);
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= ge ? diff[W-1:0] : sh[W-1:0];
                r_quo <= {r_quo[W-2:0], ge};
                r_cnt <= r_cnt - lacp_pkg::DIV_CW'(1);
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[sv/lacp_back.sv]
// Back end: sequences lookup, limit update and queue updates for one item, and holds results.
module lacp_back #(
    parameter int CACHE_SLOTS = 64,
    parameter int GHOST_SLOTS = 256,
    parameter int ADDR_BITS   = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lacp_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [lacp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               i_q_valid,
    output logic                               o_q_pop,
    input  logic [ADDR_BITS-1:0]               i_q_addr,
    input  logic                               i_q_write,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output logic [lacp_pkg::OP_W-1:0]          o_res_op,
    output logic [lacp_pkg::SLOT_W-1:0]        o_res_slot,
    output logic [lacp_pkg::EV_ADDR_W-1:0]     o_res_ev_addr,
    output logic                               o_res_ev_dirty
);

    localparam int CIW = $clog2(CACHE_SLOTS);
    localparam int CCW = $clog2(CACHE_SLOTS + 1);
    localparam int GIW = $clog2(GHOST_SLOTS);
    localparam int GCW = $clog2(GHOST_SLOTS + 1);
    localparam int LW  = (CCW > lacp_pkg::CBLK_W) ? CCW : lacp_pkg::CBLK_W;
    localparam int MW  = lacp_pkg::META_W;
    localparam int PROD_W_L = lacp_pkg::PROD_W;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DECIDE, S_DIV, S_APPLY, S_UPD, S_RES
    } t_state;

    t_state r_state;

    logic [ADDR_BITS-1:0]        r_addr;
    logic                        r_w;
    logic [lacp_pkg::CBLK_W-1:0] r_cblocks;
    logic [MW-1:0]               r_meta, r_lo, r_hi, r_limit;
    logic [CCW-1:0]              r_cc;
    logic [GCW-1:0]              r_gc;
    logic [CACHE_SLOTS-1:0]      r_dirty;
    logic                        r_cdone, r_gdone, r_cgo, r_ggo, r_cwait, r_gwait;
    lacp_pkg::t_upd_ctl          r_cctl, r_gctl;
    logic [CIW-1:0]              r_csel, r_csrank, r_cpidx;
    logic [GIW-1:0]              r_gsel, r_gsrank, r_gpidx;
    lacp_pkg::t_op               r_op;
    logic [lacp_pkg::SLOT_W-1:0] r_slot;
    logic [lacp_pkg::EV_ADDR_W-1:0] r_ev_addr;
    logic                        r_ev_dirty;
    logic                        r_res_valid;
    logic [lacp_pkg::OP_W-1:0]   r_res_op;
    logic [lacp_pkg::SLOT_W-1:0] r_res_slot;
    logic [lacp_pkg::EV_ADDR_W-1:0] r_res_ev_addr;
    logic                        r_res_ev_dirty;

    // Cache and ghost queue results
    logic                  c_done, g_done;
    lacp_pkg::t_scan_flags c_flags, g_flags;
    logic [CIW-1:0]        c_hit_idx, c_hit_rank, c_lru_idx, c_lru_rank, c_free_idx;
    logic [GIW-1:0]        g_hit_idx, g_hit_rank, g_lru_idx, g_lru_rank, g_free_idx;
    logic [ADDR_BITS-1:0]  c_lru_tag, g_lru_tag;

    logic            scan_go, div_go, div_done, res_load;
    logic [MW-1:0]   div_q, div_den, shrink_d, n_limit;
    logic [MW:0]     grow_sum;
    logic [LW-1:0]   cache_lim;
    logic            full, fail, need_div, evict, over, g_doit, g_dropv;
    logic            admit, replace, c_upd, g_upd;
    logic [CIW-1:0]  c_fidx;
    logic [GIW-1:0]  g_fidx;
    logic [PROD_W_L-1:0] lo_prod, hi_prod, cfg_prod;

    assign scan_go  = (r_state == S_IDLE) && i_q_valid;
    assign o_q_pop  = scan_go;
    assign res_load = (r_state == S_RES) && (!r_res_valid || i_res_ready);

    lacp_lru #(.DEPTH(CACHE_SLOTS), .AW(ADDR_BITS)) u_cache (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (scan_go || r_cgo),
        .i_scan     (scan_go),
        .i_addr     (r_addr),
        .i_ctl      (r_cctl),
        .i_sel_idx  (r_csel),
        .i_sel_rank (r_csrank),
        .i_push_idx (r_cpidx),
        .o_done     (c_done),
        .o_flags    (c_flags),
        .o_hit_idx  (c_hit_idx),
        .o_hit_rank (c_hit_rank),
        .o_lru_idx  (c_lru_idx),
        .o_lru_rank (c_lru_rank),
        .o_lru_tag  (c_lru_tag),
        .o_free_idx (c_free_idx)
    );

    lacp_lru #(.DEPTH(GHOST_SLOTS), .AW(ADDR_BITS)) u_ghost (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (scan_go || r_ggo),
        .i_scan     (scan_go),
        .i_addr     (r_addr),
        .i_ctl      (r_gctl),
        .i_sel_idx  (r_gsel),
        .i_sel_rank (r_gsrank),
        .i_push_idx (r_gpidx),
        .o_done     (g_done),
        .o_flags    (g_flags),
        .o_hit_idx  (g_hit_idx),
        .o_hit_rank (g_hit_rank),
        .o_lru_idx  (g_lru_idx),
        .o_lru_rank (g_lru_rank),
        .o_lru_tag  (g_lru_tag),
        .o_free_idx (g_free_idx)
    );

    lacp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (r_meta),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_q)
    );

    // Cache fill limit saturates at the number of slots.
    assign cache_lim = (LW'(r_cblocks) < LW'(CACHE_SLOTS)) ? LW'(r_cblocks) : LW'(CACHE_SLOTS);
    assign full      = (LW'(r_cc) >= cache_lim);
    assign fail      = !c_flags.hit && g_flags.hit && full && !c_flags.lru;
    assign need_div  = c_flags.hit ? (r_meta > r_limit) : (r_limit != '0);
    assign div_go    = (r_state == S_DECIDE) && !fail && need_div;
    assign div_den   = c_flags.hit ? (r_meta - r_limit) : r_limit;

    // Limit update: shrink on a cache hit, grow otherwise.
    assign shrink_d = r_limit - div_q;
    assign grow_sum = {1'b0, r_limit} + {1'b0, div_q};
    always_comb begin
        if (c_flags.hit) begin
            if (r_meta <= r_limit) begin
                n_limit = r_lo;
            end else if (div_q < r_limit) begin
                n_limit = (shrink_d > r_lo) ? shrink_d : r_lo;
            end else begin
                n_limit = r_lo;
            end
        end else if (r_limit == '0) begin
            n_limit = r_hi;
        end else begin
            n_limit = (grow_sum < {1'b0, r_hi}) ? grow_sum[MW-1:0] : r_hi;
        end
    end

    assign evict  = g_flags.hit && full;
    assign c_fidx = (evict && (!c_flags.free || c_lru_idx < c_free_idx)) ? c_lru_idx
                                                                        : c_free_idx;
    assign over    = (17'(r_gc) + 17'd1) > {1'b0, n_limit};
    assign g_doit  = !(over && r_gc == '0);
    assign g_dropv = (over || r_gc >= GCW'(GHOST_SLOTS)) && g_flags.lru;
    assign g_fidx  = (g_dropv && (!g_flags.free || g_lru_idx < g_free_idx)) ? g_lru_idx
                                                                           : g_free_idx;

    // Which queues the update sweep touches for this item.
    assign admit   = !c_flags.hit && (g_flags.hit || !full);
    assign replace = admit && evict;
    assign c_upd   = c_flags.hit || admit;
    assign g_upd   = admit ? g_flags.hit : (!c_flags.hit && g_doit);

    // meta/10 and 9*meta/10 = meta - ceil(meta/10), one multiply each.
    assign lo_prod  = PROD_W_L'(r_meta) * lacp_pkg::RECIP10;
    assign hi_prod  = (PROD_W_L'(r_meta) + PROD_W_L'(lacp_pkg::ROUND_UP10)) * lacp_pkg::RECIP10;
    assign cfg_prod = PROD_W_L'(i_cfg_data) * lacp_pkg::RECIP10;

    always_ff @(posedge i_clk) begin
        r_lo <= MW'(lo_prod >> lacp_pkg::RECIP10_SHIFT);
        r_hi <= r_meta - MW'(hi_prod >> lacp_pkg::RECIP10_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cblocks   <= lacp_pkg::CBLK_RESET;
            r_meta      <= lacp_pkg::META_RESET;
            r_limit     <= lacp_pkg::LIMIT_RESET;
            r_cc        <= '0;
            r_gc        <= '0;
            r_dirty     <= '0;
            r_cdone     <= 1'b0;
            r_gdone     <= 1'b0;
            r_cgo       <= 1'b0;
            r_ggo       <= 1'b0;
            r_cwait     <= 1'b0;
            r_gwait     <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_cgo <= (r_state == S_APPLY) && c_upd;
            r_ggo <= (r_state == S_APPLY) && g_upd;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    lacp_pkg::REG_CACHE_BLOCKS: begin
                        r_cblocks <= i_cfg_data[lacp_pkg::CBLK_W-1:0];
                    end
                    lacp_pkg::REG_META_BLOCKS: begin
                        r_meta  <= i_cfg_data;
                        r_limit <= MW'(cfg_prod >> lacp_pkg::RECIP10_SHIFT);
                    end
                    default: begin
                    end
                endcase
            end
            if (res_load) begin
                r_res_valid    <= 1'b1;
                r_res_op       <= r_op;
                r_res_slot     <= r_slot;
                r_res_ev_addr  <= r_ev_addr;
                r_res_ev_dirty <= r_ev_dirty;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (scan_go) begin
                        r_addr  <= i_q_addr;
                        r_w     <= i_q_write;
                        r_cdone <= 1'b0;
                        r_gdone <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (c_done) r_cdone <= 1'b1;
                    if (g_done) r_gdone <= 1'b1;
                    if ((r_cdone || c_done) && (r_gdone || g_done)) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (fail) begin
                        r_op       <= lacp_pkg::OP_FAIL;
                        r_slot     <= '0;
                        r_ev_addr  <= '0;
                        r_ev_dirty <= 1'b0;
                        r_state    <= S_RES;
                    end else if (need_div) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_APPLY;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_limit    <= n_limit;
                    r_cwait    <= c_upd;
                    r_gwait    <= g_upd;
                    r_ev_addr  <= replace ? lacp_pkg::EV_ADDR_W'(c_lru_tag) : '0;
                    r_ev_dirty <= replace && r_dirty[c_lru_idx];
                    r_cpidx    <= c_fidx;
                    r_gpidx    <= g_fidx;
                    r_gsel     <= admit ? g_hit_idx : g_lru_idx;
                    r_gsrank   <= admit ? g_hit_rank : g_lru_rank;
                    if (c_flags.hit) begin
                        r_cctl   <= '{touch: 1'b1, drop: 1'b0, push: 1'b0, inc: 1'b0};
                        r_gctl   <= '0;
                        r_csel   <= c_hit_idx;
                        r_csrank <= c_hit_rank;
                        r_dirty[c_hit_idx] <= r_dirty[c_hit_idx] || r_w;
                        r_op     <= lacp_pkg::OP_HIT;
                        r_slot   <= lacp_pkg::SLOT_W'(c_hit_idx);
                    end else if (admit) begin
                        // Admission: optional eviction of the LRU block, then a push at MRU.
                        r_cctl   <= '{touch: 1'b0, drop: evict, push: 1'b1, inc: 1'b1};
                        r_gctl   <= '{touch: 1'b0, drop: g_flags.hit, push: 1'b0, inc: 1'b0};
                        r_csel   <= c_lru_idx;
                        r_csrank <= c_lru_rank;
                        r_dirty[c_fidx] <= r_w;
                        r_slot   <= lacp_pkg::SLOT_W'(c_fidx);
                        r_op     <= evict ? lacp_pkg::OP_REPLACE : lacp_pkg::OP_NEW;
                        if (!evict) begin
                            r_cc <= r_cc + CCW'(1);
                        end
                        if (g_flags.hit) begin
                            r_gc <= r_gc - GCW'(1);
                        end
                    end else begin
                        // Filtered into the ghost queue, oldest ghost dropped when over limit or the store is full.
                        r_cctl   <= '0;
                        r_gctl   <= '{touch: 1'b0, drop: g_dropv, push: 1'b1, inc: 1'b1};
                        r_csel   <= c_lru_idx;
                        r_csrank <= c_lru_rank;
                        r_op     <= lacp_pkg::OP_FILTER;
                        r_slot   <= '0;
                        if (g_doit && !g_dropv) begin
                            r_gc <= r_gc + GCW'(1);
                        end
                    end
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    if (c_done) r_cwait <= 1'b0;
                    if (g_done) r_gwait <= 1'b0;
                    if ((!r_cwait || c_done) && (!r_gwait || g_done)) begin
                        r_state <= S_RES;
                    end
                end
                S_RES: begin
                    if (res_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid    = r_res_valid;
    assign o_res_op       = r_res_op;
    assign o_res_slot     = r_res_slot;
    assign o_res_ev_addr  = r_res_ev_addr;
    assign o_res_ev_dirty = r_res_ev_dirty;

    // The ghost LRU tag is not needed: a dropped ghost is just forgotten.
    logic unused_ghost_tag;
    assign unused_ghost_tag = ^g_lru_tag;

    a_cc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cc <= CCW'(CACHE_SLOTS))
        else $error("cached count exceeds the slot count");

    a_gc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gc <= GCW'(GHOST_SLOTS))
        else $error("ghost count exceeds the ghost store");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |-> !(c_flags.hit && g_flags.hit))
        else $error("block found in both the cache and the ghost queue");

    a_victim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && !c_flags.hit && evict) |-> c_flags.lru)
        else $error("eviction without a victim");

endmodule

[sv/larc_cache_admission_policy.sv]
// Top level of the lazy adaptive cache admission policy: front queue and back sequencer.
//
//  Channel  | Direction | Handshake               | Payload
//  ---------+-----------+-------------------------+--------------------------------------
//  s_axis   | in        | s_axis_tvalid/tready    | tdata: block_addr, is_write
//  m_axis   | out       | m_axis_tvalid/tready    | tdata: op, cache_slot, evicted_addr,
//           |           |                         |        evicted_dirty
//  cfg      | in        | i_cfg_we                | i_cfg_idx, i_cfg_data
//
// Each item is processed on its own. The back end sweeps the cache and ghost tag memories
// in parallel, one entry per cycle, for the lookup. The limit update then runs the serial
// divider when needed, and the rank update sweeps the touched queues again. With the
// default sizes the ghost sweep, through the ghost memory's single read port, is the
// longest step of an item.
// Reset is synchronous and active low; it clears all valid bits and counts at once, so no
// clearing pass is needed. A two-entry input queue lets the front accept items while the back
// works, and a result register lets the back finish its next item while a result waits.
module larc_cache_admission_policy #(
    parameter int CACHE_SLOTS = 64,
    parameter int GHOST_SLOTS = 256,
    parameter int ADDR_BITS   = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // block_addr [31:0], is_write [32], zero fill above
    input  logic [lacp_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // op [2:0], cache_slot [8:3], evicted_addr [40:9], evicted_dirty [41], zero fill above
    output logic [lacp_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_we,
    input  logic [lacp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lacp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic                                q_valid, q_pop, q_write;
    logic [ADDR_BITS-1:0]                q_addr;
    logic [lacp_pkg::OP_W-1:0]           res_op;
    logic [lacp_pkg::SLOT_W-1:0]         res_slot;
    logic [lacp_pkg::EV_ADDR_W-1:0]      res_ev_addr;
    logic                                res_ev_dirty;

    lacp_front #(.ADDR_BITS(ADDR_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_in_addr  (s_axis_tdata[lacp_pkg::IN_ADDR_W-1:0]),
        .i_in_write (s_axis_tdata[lacp_pkg::IN_ADDR_W]),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_addr   (q_addr),
        .o_q_write  (q_write)
    );

    lacp_back #(
        .CACHE_SLOTS (CACHE_SLOTS),
        .GHOST_SLOTS (GHOST_SLOTS),
        .ADDR_BITS   (ADDR_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (q_valid),
        .o_q_pop        (q_pop),
        .i_q_addr       (q_addr),
        .i_q_write      (q_write),
        .o_res_valid    (m_axis_tvalid),
        .i_res_ready    (m_axis_tready),
        .o_res_op       (res_op),
        .o_res_slot     (res_slot),
        .o_res_ev_addr  (res_ev_addr),
        .o_res_ev_dirty (res_ev_dirty)
    );

    assign m_axis_tdata = {6'd0, res_ev_dirty, res_ev_addr, res_slot, res_op};

endmodule

[dv/larc_access_checker.sv]
// Checker that predicts and compares the admission decisions of the cache policy block.
`timescale 1ns / 1ps

module larc_access_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    input  logic                                i_s_tready,
    input  logic [lacp_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    input  logic                                i_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [lacp_pkg::OUT_TDATA_W-1:0]    i_m_tdata,
    input  logic                                i_cfg_we,
    input  logic [lacp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lacp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    localparam int NC = 64;
    localparam int NG = 256;

    typedef struct packed {
        lacp_pkg::t_op op;
        logic [5:0]    slot;
        logic [31:0]   ev_addr;
        logic          ev_dirty;
    } t_decision;

    t_decision   expected_decisions[$];

    logic [31:0] c_tag[NC];
    logic        c_val[NC];
    logic        c_dirty[NC];
    int          c_rank[NC];
    logic [31:0] g_tag[NG];
    logic        g_val[NG];
    int          g_rank[NG];
    int unsigned ghost_limit, cached_n, ghost_n, cache_blocks, meta_blocks;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    task automatic clear_state();
        for (int i = 0; i < NC; i++) begin
            c_tag[i] = '0; c_val[i] = 1'b0; c_dirty[i] = 1'b0; c_rank[i] = 0;
        end
        for (int i = 0; i < NG; i++) begin
            g_tag[i] = '0; g_val[i] = 1'b0; g_rank[i] = 0;
        end
        cache_blocks = 64;
        meta_blocks  = 256;
        ghost_limit  = 25;
        cached_n     = 0;
        ghost_n      = 0;
    endtask

    // Works out the decision for one access and updates the shadow queues.
    task automatic predict_access(input logic [31:0] a, input logic w);
        int c, g, v, f, r;
        int unsigned m, gl, t, lo, hi, newlim, cap;
        logic full, over;
        t_decision d;
        d = '0;
        d.op = lacp_pkg::OP_FILTER;
        c = -1;
        g = -1;
        m = meta_blocks;
        gl = ghost_limit;
        for (int i = NC - 1; i >= 0; i--) if (c_val[i] && c_tag[i] == a) c = i;
        if (c >= 0) begin
            // Hit: shrink the ghost limit toward a tenth of the metadata size.
            lo = m / 10;
            if (m <= gl) ghost_limit = lo;
            else begin
                t = m / (m - gl);
                ghost_limit = (t < gl && (gl - t) > lo) ? gl - t : lo;
            end
            r = c_rank[c];
            for (int i = 0; i < NC; i++) if (c_val[i] && c_rank[i] < r) c_rank[i]++;
            c_rank[c] = 0;
            c_dirty[c] = c_dirty[c] | w;
            d.op = lacp_pkg::OP_HIT;
            d.slot = c[5:0];
        end else begin
            for (int i = NG - 1; i >= 0; i--) if (g_val[i] && g_tag[i] == a) g = i;
            hi = (9 * m) / 10;
            if (gl == 0) newlim = hi;
            else newlim = (gl + m / gl < hi) ? gl + m / gl : hi;
            cap = (cache_blocks < NC) ? cache_blocks : NC;
            full = (cached_n >= cap);
            if (g >= 0 || !full) begin
                d.op = lacp_pkg::OP_NEW;
                if (g >= 0 && full) begin
                    v = -1;
                    for (int i = 0; i < NC; i++)
                        if (c_val[i] && (v < 0 || c_rank[i] > c_rank[v])) v = i;
                    if (v < 0) begin
                        // Ghost hit with nothing to evict: no state changes.
                        d = '0;
                        d.op = lacp_pkg::OP_FAIL;
                        expected_decisions.push_back(d);
                        return;
                    end
                    d.ev_addr = c_tag[v];
                    d.ev_dirty = c_dirty[v];
                    r = c_rank[v];
                    for (int i = 0; i < NC; i++) if (c_val[i] && c_rank[i] > r) c_rank[i]--;
                    c_val[v] = 1'b0;
                    cached_n--;
                    d.op = lacp_pkg::OP_REPLACE;
                end
                if (g >= 0) begin
                    r = g_rank[g];
                    for (int i = 0; i < NG; i++) if (g_val[i] && g_rank[i] > r) g_rank[i]--;
                    g_val[g] = 1'b0;
                    ghost_n--;
                end
                f = -1;
                for (int i = NC - 1; i >= 0; i--) if (!c_val[i]) f = i;
                if (f >= 0) begin
                    c_tag[f] = a;
                    c_dirty[f] = w;
                    for (int i = 0; i < NC; i++) if (c_val[i]) c_rank[i]++;
                    c_val[f] = 1'b1;
                    c_rank[f] = 0;
                    cached_n++;
                    d.slot = f[5:0];
                end
            end else begin
                over = (ghost_n + 1 > newlim);
                if (!(over && ghost_n == 0)) begin
                    if (over || ghost_n >= NG) begin
                        v = -1;
                        for (int i = 0; i < NG; i++)
                            if (g_val[i] && (v < 0 || g_rank[i] > g_rank[v])) v = i;
                        if (v >= 0) begin
                            r = g_rank[v];
                            for (int i = 0; i < NG; i++)
                                if (g_val[i] && g_rank[i] > r) g_rank[i]--;
                            g_val[v] = 1'b0;
                            ghost_n--;
                        end
                    end
                    f = -1;
                    for (int i = NG - 1; i >= 0; i--) if (!g_val[i]) f = i;
                    if (f >= 0) begin
                        g_tag[f] = a;
                        for (int i = 0; i < NG; i++) if (g_val[i]) g_rank[i]++;
                        g_val[f] = 1'b1;
                        g_rank[f] = 0;
                        ghost_n++;
                    end
                end
            end
            ghost_limit = newlim & 32'hFFFF;
        end
        expected_decisions.push_back(d);
    endtask

    always @(posedge i_clk) begin
        t_decision want, got;
        if (!i_rst_n) begin
            clear_state();
            expected_decisions.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == lacp_pkg::REG_CACHE_BLOCKS) cache_blocks = i_cfg_data & 16'h7F;
                else if (i_cfg_idx == lacp_pkg::REG_META_BLOCKS) begin
                    meta_blocks = i_cfg_data;
                    ghost_limit = meta_blocks / 10;
                end
            end
            if (i_s_tvalid && i_s_tready) predict_access(i_s_tdata[31:0], i_s_tdata[32]);
            if (i_m_tvalid && i_m_tready) begin
                got.op       = lacp_pkg::t_op'(i_m_tdata[2:0]);
                got.slot     = i_m_tdata[8:3];
                got.ev_addr  = i_m_tdata[40:9];
                got.ev_dirty = i_m_tdata[41];
                if (expected_decisions.size() == 0) begin
                    $display("%0t: unexpected result, actual %h", $time, i_m_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_decisions.pop_front();
                    if (want.op !== got.op || want.slot !== got.slot ||
                        want.ev_addr !== got.ev_addr || want.ev_dirty !== got.ev_dirty) begin
                        $display("%0t: op exp %0d act %0d, slot exp %0d act %0d",
                                 $time, want.op, got.op, want.slot, got.slot);
                        $display("%0t: evicted exp %h/%b act %h/%b", $time,
                                 want.ev_addr, want.ev_dirty, got.ev_addr, got.ev_dirty);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= expected_decisions.size();
    end

endmodule

[dv/tb.sv]
// Testbench top that drives accesses and configuration into the cache admission policy block.
`timescale 1ns / 1ps

module tb;

    // The limit leaves a wide margin over the whole run.
    localparam int CYCLE_LIMIT = 5000000;

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             s_tvalid = 1'b0;
    logic                             s_tready;
    logic [lacp_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                             m_tvalid;
    logic                             m_tready = 1'b0;
    logic [lacp_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                             cfg_we = 1'b0;
    logic [lacp_pkg::CFG_IDX_W-1:0]   cfg_idx = '0;
    logic [lacp_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
    int                               fail_count, pending;
    int                               gap_pct = 0, stall_pct = 0, cycles = 0;
    logic [31:0]                      addr_pool[96];

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    larc_cache_admission_policy DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_tvalid), .s_axis_tready(s_tready), .s_axis_tdata(s_tdata),
        .m_axis_tvalid(m_tvalid), .m_axis_tready(m_tready), .m_axis_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    larc_access_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // The result side stalls at random according to the current phase.
    always @(negedge i_clk) m_tready <= ($urandom_range(99) >= stall_pct);

    // Watchdog over the whole run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("larc_cache_admission_policy: mismatch");
            $finish;
        end
    end

    // Offers one access; called and returns at a falling edge. A gap lowers valid first.
    task automatic send_access(input logic [31:0] addr, input logic wr);
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, wr, addr};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    // Drops valid and waits until every access has been answered.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [lacp_pkg::CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly reused addresses so that hits and ghost hits happen, some fully random.
    function automatic logic [31:0] pick_addr();
        if ($urandom_range(99) < 75) return addr_pool[$urandom_range(95)];
        return $urandom;
    endfunction

    initial begin
        logic [15:0] cval, mval;
        for (int i = 0; i < 96; i++) addr_pool[i] = $urandom;
        addr_pool[0] = 32'h0;
        addr_pool[1] = 32'hFFFF_FFFF;

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // A zero ghost limit with an empty ghost queue drops the filtered block itself.
        write_reg(lacp_pkg::REG_CACHE_BLOCKS, 16'd0);
        write_reg(lacp_pkg::REG_META_BLOCKS, 16'd0);
        send_access(32'h0000_0B0B, 1'b0);
        drain();
        // With no cache slots, a ghost hit finds nothing to evict and fails.
        write_reg(lacp_pkg::REG_META_BLOCKS, 16'd256);
        send_access(32'h0000_0A0A, 1'b0);
        send_access(32'h0000_0A0A, 1'b1);
        drain();
        // Two slots: fills, hits, filters and replaces with clean and dirty victims.
        write_reg(lacp_pkg::REG_CACHE_BLOCKS, 16'd2);
        send_access(32'h0, 1'b1);
        send_access(32'hFFFF_FFFF, 1'b0);
        send_access(32'h0, 1'b0);
        send_access(32'h1234_5678, 1'b0);
        send_access(32'h1234_5678, 1'b1);
        send_access(32'h0, 1'b0);
        send_access(32'h8765_4321, 1'b1);
        send_access(32'h8765_4321, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b1);
        drain();
        // A count past the slot total saturates.
        write_reg(lacp_pkg::REG_CACHE_BLOCKS, 16'hFF80 | 16'd127);
        send_access(32'h5555_AAAA, 1'b1);
        drain();
        // Lowering the count below what is cached makes every admission evict.
        write_reg(lacp_pkg::REG_CACHE_BLOCKS, 16'd1);
        send_access(32'hAAAA_5555, 1'b0);
        send_access(32'hAAAA_5555, 1'b0);
        drain();
        // A huge ghost limit lets distinct misses overflow the ghost store.
        write_reg(lacp_pkg::REG_META_BLOCKS, 16'hFFFF);
        for (int i = 0; i < 300; i++) send_access($urandom, $urandom_range(1));
        drain();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 65; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 65; end
                default: begin gap_pct = 38; stall_pct = 38; end
            endcase
            case ($urandom_range(4))
                0: cval = 16'd1;
                1: cval = 16'd64;
                2: cval = 16'd127;
                3: cval = 16'd8;
                default: cval = 16'($urandom_range(127));
            endcase
            cval[15:7] = 9'($urandom);
            case ($urandom_range(3))
                0: mval = 16'd10;
                1: mval = 16'hFFFF;
                2: mval = 16'($urandom_range(10, 400));
                default: mval = 16'($urandom);
            endcase
            write_reg(lacp_pkg::REG_CACHE_BLOCKS, cval);
            write_reg(lacp_pkg::REG_META_BLOCKS, mval);
            for (int i = 0; i < 180; i++) send_access(pick_addr(), $urandom_range(1));
            // The sender holds off here until every answer is back.
            drain();
            for (int i = 0; i < 60; i++) send_access(pick_addr(), $urandom_range(1));
            drain();
        end

        if (fail_count == 0) begin
            $display("larc_cache_admission_policy: match");
        end else begin
            $display("larc_cache_admission_policy: mismatch");
        end
        $finish;
    end

endmodule
